FILE: hdl/fdd_pkg.sv
// fdd_pkg: shared types, register indexes and reset values of the floor
// range drop-off detector
// no dependencies
package fdd_pkg;

    localparam int HIST_DEPTH_DEF = 64;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCEND_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DESCEND_WINDOW = 3'd5;

    localparam logic [11:0] RST_CLIMB_FACTOR   = 12'd307;
    localparam logic [11:0] RST_DESCEND_FACTOR = 12'd1024;
    localparam logic [7:0]  RST_PEAK_HOLD      = 8'd10;
    localparam logic [15:0] RST_CLIMB_MIN      = 16'd30;
    localparam logic [5:0]  RST_CLIMB_WINDOW   = 6'd30;
    localparam logic [5:0]  RST_DESCEND_WINDOW = 6'd50;

    typedef struct packed {
        logic [11:0] climb_factor;
        logic [11:0] descend_factor;
        logic [7:0]  peak_hold;
        logic [15:0] climb_min_count;
        logic [5:0]  climb_window;
        logic [5:0]  descend_window;
    } t_cfg;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        climb_start;
    } t_item;

endpackage

FILE: hdl/fdd_ram.sv
// fdd_ram: generic single write, single read RAM with registered read
// no dependencies
module fdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/fdd_front.sv
// fdd_front: two-entry request queue between the input channel and the
// processing sequencer; depends on fdd_pkg
module fdd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fdd_pkg::t_item i_item,
    output logic          o_q_valid,
    output fdd_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    import fdd_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: hdl/fdd_div.sv
// fdd_div: restoring divider, one quotient bit per cycle, for the history mean
// no dependencies
module fdd_div #(
    parameter int NW = 23,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   trial;
    logic          take;

    assign trial = {r_rem, r_quo[NW-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= take ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_quo  <= {r_quo[NW-2:0], take};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
            // last quotient bit lands on this edge
            r_done <= !i_go && r_busy && (r_cnt == CW'(1));
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: hdl/fdd_back.sv
// fdd_back: sequencer that carries out one request: peak tracking, threshold
// tests, history ring upkeep and mean; depends on fdd_pkg, fdd_ram, fdd_div
module fdd_back #(
    parameter int HIST_DEPTH = fdd_pkg::HIST_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fdd_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  fdd_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_stop_request,
    output logic           o_descend_detected,
    output logic [15:0]    o_mean_mm
);
    import fdd_pkg::*;

    localparam int AW = $clog2(HIST_DEPTH);
    localparam int FW = $clog2(HIST_DEPTH + 1);
    localparam int SW = 16 + FW;
    localparam int CW = (FW > 6) ? FW : 6;
    localparam int TW = AW + 2;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_PEAK      = 13'b0000000000010,
        S_MUL       = 13'b0000000000100,
        S_CMP       = 13'b0000000001000,
        S_FULL_RD   = 13'b0000000010000,
        S_FULL_SUB  = 13'b0000000100000,
        S_PUSH      = 13'b0000001000000,
        S_DIV_GO    = 13'b0000010000000,
        S_DIV       = 13'b0000100000000,
        S_TRIM_RD   = 13'b0001000000000,
        S_TRIM_SUB  = 13'b0010000000000,
        S_OUT       = 13'b0100000000000,
        S_SPARE     = 13'b1000000000000
    } t_state;

    t_state        r_state;
    logic          r_climbing, r_desc;
    logic [15:0]   r_peak, r_count, r_pidx, r_mean, r_range, r_push_val;
    logic [FW-1:0] r_fill;
    logic [AW-1:0] r_head;
    logic [SW-1:0] r_sum;
    logic [27:0]   r_prod;
    logic          r_stop;
    logic          r_out_valid, r_out_stop, r_out_desc;
    logic [15:0]   r_out_mean;

    logic          out_free;
    logic [15:0]   new_pidx, new_peak, age;
    logic          push_en, exceeds, full, over_win;
    logic [TW-1:0] tail_sum;
    logic [AW-1:0] tail, head_inc;
    logic [11:0]   factor;
    logic [5:0]    window;
    logic [15:0]   rdata;
    logic          ram_we, div_done;
    logic [SW-1:0] div_quo;
    t_state        push_start, push_end;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        new_peak = (r_range > r_peak) ? r_range : r_peak;
        new_pidx = (r_range > r_peak) ? r_count : r_pidx;
        age      = r_count - new_pidx;
        push_en  = (r_count >= new_pidx) && (age > {8'd0, i_cfg.peak_hold});
        factor   = r_climbing ? i_cfg.climb_factor : i_cfg.descend_factor;
        window   = r_climbing ? i_cfg.climb_window : i_cfg.descend_window;
        exceeds  = {4'd0, r_range, 8'd0} > r_prod;
        full     = (r_fill == FW'(HIST_DEPTH));
        over_win = CW'(r_fill) > CW'(window);
        tail_sum = TW'(r_head) + TW'(r_fill);
        tail     = (tail_sum >= TW'(HIST_DEPTH)) ? AW'(tail_sum - TW'(HIST_DEPTH))
                                                 : AW'(tail_sum);
        head_inc = (r_head == AW'(HIST_DEPTH - 1)) ? '0 : r_head + AW'(1);
        push_start = full ? S_FULL_RD : S_PUSH;
        push_end   = r_climbing ? S_MUL : S_OUT;
        ram_we     = (r_state == S_PUSH);
    end

    fdd_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (r_push_val),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    fdd_div #(.NW(SW), .DW(FW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_state == S_DIV_GO),
        .i_num   (r_sum),
        .i_den   (r_fill),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_climbing  <= 1'b0;
            r_desc      <= 1'b0;
            r_peak      <= '0;
            r_count     <= '0;
            r_pidx      <= '0;
            r_mean      <= '0;
            r_fill      <= '0;
            r_head      <= '0;
            r_sum       <= '0;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_range <= i_q_item.range_mm;
                        r_stop  <= 1'b0;
                        if (i_q_item.climb_start) begin
                            r_climbing <= 1'b1;
                            r_peak     <= '0;
                            r_count    <= '0;
                            r_pidx     <= '0;
                            r_mean     <= '0;
                            r_fill     <= '0;
                            r_head     <= '0;
                            r_sum      <= '0;
                        end
                        r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (r_climbing) begin
                        r_peak     <= new_peak;
                        r_pidx     <= new_pidx;
                        r_push_val <= new_peak;
                        r_state    <= push_en ? push_start : S_MUL;
                    end else begin
                        r_push_val <= r_range;
                        r_state    <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= factor * r_mean;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_climbing) begin
                        r_stop  <= exceeds && (r_count > i_cfg.climb_min_count)
                                   && (r_mean != '0);
                        r_state <= S_OUT;
                    end else begin
                        if (exceeds && (r_mean != '0)) begin
                            r_desc <= 1'b1;
                            r_stop <= 1'b1;
                        end
                        r_state <= push_start;
                    end
                end
                S_FULL_RD:  r_state <= S_FULL_SUB;
                S_FULL_SUB: begin
                    r_sum   <= r_sum - SW'(rdata);
                    r_head  <= head_inc;
                    r_fill  <= r_fill - FW'(1);
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    r_sum   <= r_sum + SW'(r_push_val);
                    r_fill  <= r_fill + FW'(1);
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_mean  <= div_quo[15:0];
                        r_state <= over_win ? S_TRIM_RD : push_end;
                    end
                end
                S_TRIM_RD:  r_state <= S_TRIM_SUB;
                S_TRIM_SUB: begin
                    r_sum   <= r_sum - SW'(rdata);
                    r_head  <= head_inc;
                    r_fill  <= r_fill - FW'(1);
                    r_state <= push_end;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_stop  <= r_stop;
                        r_out_desc  <= r_desc;
                        r_out_mean  <= r_mean;
                        if (r_climbing && (r_count != 16'hFFFF)) begin
                            r_count <= r_count + 16'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_stop_request     = r_out_stop;
    assign o_descend_detected = r_out_desc;
    assign o_mean_mm          = r_out_mean;
endmodule

FILE: hdl/floor_range_dropoff_detector_unit.sv
// requests: the sequencer carries out one request at a time and does not take
// the next until it is through with the last; the bit-serial mean divider sets
// the longest request, and a two-entry queue holds later requests
// reset: synchronous active low, clears mode, flags, counters, history fill
// and restores register defaults; ring contents are not cleared
module floor_range_dropoff_detector_unit #(
    parameter int HIST_DEPTH = fdd_pkg::HIST_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [15:0]                    i_range_mm,
    input  logic                           i_climb_start,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_stop_request,
    output logic                           o_descend_detected,
    output logic [15:0]                    o_mean_mm,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fdd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fdd_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import fdd_pkg::*;

    t_cfg  r_cfg;
    t_item in_item, q_item;
    logic  q_valid, q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.climb_factor    <= RST_CLIMB_FACTOR;
            r_cfg.descend_factor  <= RST_DESCEND_FACTOR;
            r_cfg.peak_hold       <= RST_PEAK_HOLD;
            r_cfg.climb_min_count <= RST_CLIMB_MIN;
            r_cfg.climb_window    <= RST_CLIMB_WINDOW;
            r_cfg.descend_window  <= RST_DESCEND_WINDOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CLIMB_FACTOR:   r_cfg.climb_factor    <= i_cfg_data[11:0];
                REG_DESCEND_FACTOR: r_cfg.descend_factor  <= i_cfg_data[11:0];
                REG_PEAK_HOLD:      r_cfg.peak_hold       <= i_cfg_data[7:0];
                REG_CLIMB_MIN:      r_cfg.climb_min_count <= i_cfg_data;
                REG_CLIMB_WINDOW:   r_cfg.climb_window    <= i_cfg_data[5:0];
                REG_DESCEND_WINDOW: r_cfg.descend_window  <= i_cfg_data[5:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    assign in_item.range_mm    = i_range_mm;
    assign in_item.climb_start = i_climb_start;

    fdd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (in_item),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    fdd_back #(.HIST_DEPTH(HIST_DEPTH)) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_valid          (q_valid),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_stop_request     (o_stop_request),
        .o_descend_detected (o_descend_detected),
        .o_mean_mm          (o_mean_mm)
    );
endmodule

FILE: hdl/fdd_chk.sv
// fdd_chk: port-level checks of the drop-off detector, bound to the top level
// depends on floor_range_dropoff_detector_unit ports only
module fdd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_stop_request,
    input logic        o_descend_detected,
    input logic [15:0] o_mean_mm
);
    logic       in_acc, out_acc;
    logic [3:0] r_pend;
    logic       r_seen_desc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_seen_desc <= 1'b0;
        end else begin
            r_pend <= r_pend + 4'(in_acc) - 4'(out_acc);
            if (out_acc && o_descend_detected) r_seen_desc <= 1'b1;
        end
    end

    // a result is only accepted while a request is outstanding
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pend != 4'd0))
        else $error("result without request");

    // descend flag is sticky until reset
    a_desc_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_seen_desc) |-> o_descend_detected)
        else $error("descend flag dropped");

    // never more requests in flight than queue, sequencer and output hold
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'd4)
        else $error("too many requests in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_mean_mm) && $stable(o_stop_request)))
        else $error("stalled result changed");
endmodule

bind floor_range_dropoff_detector_unit fdd_chk u_fdd_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_stop_request     (o_stop_request),
    .o_descend_detected (o_descend_detected),
    .o_mean_mm          (o_mean_mm)
);

FILE: tb/fdd_checker.sv
// fdd_checker: watches the request, result and register channels of the floor
// range drop-off detector, predicts every result and compares it on arrival
// depends on fdd_pkg
`timescale 1ns / 100ps

module fdd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [15:0]                   i_range_mm,
    input  logic                          i_climb_start,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_stop_request,
    input  logic                          i_descend_detected,
    input  logic [15:0]                   i_mean_mm,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [fdd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fdd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);
    import fdd_pkg::*;

    localparam int DEPTH = HIST_DEPTH_DEF;
    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic        stop;
        logic        descend;
        logic [15:0] mean;
    } t_verdict;

    // expected results in request order
    t_verdict    exp_mem [EXP_DEPTH];
    int unsigned exp_wr;
    int unsigned exp_rd;

    t_cfg        cfg;
    logic        climbing;
    logic        descend_flag;
    int unsigned peak_mm;
    int unsigned n_samples;
    int unsigned peak_at;
    int unsigned mean_mm;
    logic [15:0] ring [DEPTH];
    int unsigned fill;
    int unsigned head;
    int unsigned sum_mm;

    task automatic drop_oldest();
        if (fill != 0) begin
            sum_mm -= ring[head];
            head = (head + 1) % DEPTH;
            fill--;
        end
    endtask

    task automatic push_sample(input int unsigned v, input int unsigned window);
        int unsigned tail;
        if (fill >= DEPTH) drop_oldest();
        tail = (head + fill) % DEPTH;
        ring[tail] = v[15:0];
        sum_mm += v[15:0];
        fill++;
        mean_mm = (sum_mm / fill) & 16'hFFFF;
        if (fill > window) drop_oldest();
    endtask

    function automatic logic above(input int unsigned r, input int unsigned factor);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = longint'(r) << 8;
        rhs = longint'(factor) * longint'(mean_mm);
        return lhs > rhs;
    endfunction

    task automatic predict_sample(input logic [15:0] r, input logic start,
                                  output t_verdict v);
        logic stop;
        stop = 1'b0;
        if (start) begin
            climbing  = 1'b1;
            peak_mm   = 0;
            n_samples = 0;
            peak_at   = 0;
            mean_mm   = 0;
            fill = 0; head = 0; sum_mm = 0;
        end
        if (climbing) begin
            if (r > peak_mm) begin
                peak_mm = r;
                peak_at = n_samples;
            end
            if (n_samples >= peak_at && n_samples - peak_at > cfg.peak_hold)
                push_sample(peak_mm, cfg.climb_window);
            if (above(r, cfg.climb_factor) && n_samples > cfg.climb_min_count &&
                mean_mm > 0)
                stop = 1'b1;
            if (n_samples < 16'hFFFF) n_samples++;
        end else begin
            if (above(r, cfg.descend_factor) && mean_mm > 0) begin
                descend_flag = 1'b1;
                stop = 1'b1;
            end
            push_sample(r, cfg.descend_window);
        end
        v.stop    = stop;
        v.descend = descend_flag;
        v.mean    = mean_mm[15:0];
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            cfg = '{RST_CLIMB_FACTOR, RST_DESCEND_FACTOR, RST_PEAK_HOLD,
                    RST_CLIMB_MIN, RST_CLIMB_WINDOW, RST_DESCEND_WINDOW};
            climbing = 1'b0; descend_flag = 1'b0;
            peak_mm = 0; n_samples = 0; peak_at = 0; mean_mm = 0;
            fill = 0; head = 0; sum_mm = 0;
            exp_wr = 0; exp_rd = 0;
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CLIMB_FACTOR:   cfg.climb_factor    = i_cfg_data[11:0];
                    REG_DESCEND_FACTOR: cfg.descend_factor  = i_cfg_data[11:0];
                    REG_PEAK_HOLD:      cfg.peak_hold       = i_cfg_data[7:0];
                    REG_CLIMB_MIN:      cfg.climb_min_count = i_cfg_data[15:0];
                    REG_CLIMB_WINDOW:   cfg.climb_window    = i_cfg_data[5:0];
                    REG_DESCEND_WINDOW: cfg.descend_window  = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_stop_request, i_descend_detected, i_mean_mm};
                if (exp_wr == exp_rd) begin
                    $error("result with no request outstanding");
                    o_errors++;
                end else begin
                    want = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (got.stop !== want.stop) begin
                        $error("stop_request: expected %0d, got %0d", want.stop, got.stop);
                        o_errors++;
                    end
                    if (got.descend !== want.descend) begin
                        $error("descend_detected: expected %0d, got %0d",
                               want.descend, got.descend);
                        o_errors++;
                    end
                    if (got.mean !== want.mean) begin
                        $error("mean_mm: expected %0d, got %0d", want.mean, got.mean);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_sample(i_range_mm, i_climb_start, want);
                exp_mem[exp_wr % EXP_DEPTH] = want;
                exp_wr++;
            end
        end
        o_pending = int'(exp_wr - exp_rd);
    end

endmodule

FILE: tb/tb_floor_range_dropoff_detector_unit.sv
// tb_floor_range_dropoff_detector_unit: drives samples, register writes and
// result stalls into the drop-off detector and reports the verdict
// depends on fdd_pkg, floor_range_dropoff_detector_unit and fdd_checker
`timescale 1ns / 100ps

module tb_floor_range_dropoff_detector_unit;
    import fdd_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [15:0]          i_range_mm;
    logic                 i_climb_start;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_stop_request;
    logic                 o_descend_detected;
    logic [15:0]          o_mean_mm;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    int                   n_errors;
    int                   n_pending;
    logic                 no_gaps;

    floor_range_dropoff_detector_unit u_dut (.*);

    fdd_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_range_mm,
        .i_climb_start, .i_out_valid(o_out_valid), .i_out_stall,
        .i_stop_request(o_stop_request), .i_descend_detected(o_descend_detected),
        .i_mean_mm(o_mean_mm), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_errors(n_errors), .o_pending(n_pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("tb_floor_range_dropoff_detector_unit: errors");
        $finish;
    end

    // result side: random stall before each result, none while no_gaps is set
    initial begin
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_out_stall = 1'b1;
            repeat (no_gaps ? 0 : $urandom_range(0, 8)) @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_sample(input logic [15:0] r, input logic start);
        i_in_valid = 1'b0;
        repeat (no_gaps ? 0 : $urandom_range(0, 8)) @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_range_mm    = r;
        i_climb_start = start;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // every result back, then margin for the divider
    task automatic wait_idle();
        while (n_pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int unsigned pick_edge(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic logic [15:0] floor_noise(input int unsigned base);
        case ($urandom_range(0, 15))
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'hFFFF;
            default: return 16'(base + $urandom_range(0, 60));
        endcase
    endfunction

    initial begin
        int unsigned base;
        int unsigned len;
        int unsigned peak_pos;
        int unsigned r;
        int          sent;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_range_mm = '0; i_climb_start = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0; no_gaps = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // flat floor: zero mean, full range, then a drop-off spike
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b0);
        wait_idle();
        // window of zero trims to empty each time, factor zero trips on any nonzero range once the mean is nonzero
        write_reg(REG_DESCEND_WINDOW, 0);
        write_reg(REG_DESCEND_FACTOR, 0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd1, 1'b0);
        wait_idle();
        write_reg(REG_DESCEND_WINDOW, 1);
        write_reg(REG_DESCEND_FACTOR, 4095);
        send_sample(16'd40, 1'b0);
        send_sample(16'd40, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        wait_idle();

        // descend phases before any climb, since only reset leaves climbing
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_DESCEND_FACTOR, pick_edge(0, 4095));
            write_reg(REG_DESCEND_WINDOW, pick_edge(1, 63));
            no_gaps = (ph % 2 == 1);
            base = $urandom_range(0, 3000);
            repeat ($urandom_range(50, 90)) begin
                send_sample(floor_noise(base), 1'b0);
                sent++;
            end
            wait_idle();
        end
        no_gaps = 1'b0;

        // directed climb: stop once past the minimum count and hold
        write_reg(REG_PEAK_HOLD, 0);
        write_reg(REG_CLIMB_MIN, 0);
        write_reg(REG_CLIMB_FACTOR, 0);
        write_reg(REG_CLIMB_WINDOW, 0);
        send_sample(16'd1000, 1'b1);
        send_sample(16'd900, 1'b0);
        send_sample(16'd950, 1'b0);
        wait_idle();
        write_reg(REG_CLIMB_WINDOW, 63);
        write_reg(REG_CLIMB_FACTOR, 4095);
        send_sample(16'd300, 1'b1);
        send_sample(16'd200, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b0);
        wait_idle();

        // climb phases: ramp to a peak, fall away, with the odd spike or restart
        for (int ph = 0; sent < 600; ph++) begin
            write_reg(REG_CLIMB_FACTOR, pick_edge(0, 4095));
            write_reg(REG_PEAK_HOLD, ($urandom_range(0, 5) == 0) ? 255 : pick_edge(0, 12));
            write_reg(REG_CLIMB_MIN, ($urandom_range(0, 5) == 0) ? 65535 : pick_edge(0, 40));
            write_reg(REG_CLIMB_WINDOW, ($urandom_range(0, 7) == 0) ? 0 : pick_edge(1, 63));
            no_gaps = (ph % 3 == 2);
            repeat ($urandom_range(2, 4)) begin
                len      = $urandom_range(10, 70);
                peak_pos = $urandom_range(1, len);
                base     = $urandom_range(100, 4000);
                for (int k = 0; k < len; k++) begin
                    if (k <= peak_pos) r = base + k * $urandom_range(0, 80);
                    else r = base + peak_pos * 40 - (k - peak_pos) * $urandom_range(0, 60);
                    if ($urandom_range(0, 12) == 0) r = $urandom;
                    send_sample(16'(r), k == 0 || $urandom_range(0, 40) == 0);
                    sent++;
                end
            end
            wait_idle();
        end

        wait_idle();
        if (n_errors == 0)
            $display("tb_floor_range_dropoff_detector_unit: clean");
        else
            $display("tb_floor_range_dropoff_detector_unit: errors");
        $finish;
    end

endmodule
